[rtl/twlc_pkg.sv]
// Shared types and constants for the two-level write-back cache.
// No dependencies; imported by every other file of the block.
`default_nettype none

package twlc_pkg;

    localparam int ADDR_W    = 16;
    localparam int WORD_W    = 32;
    localparam int TIME_W    = 32;
    localparam int COST_W    = 10;
    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_L1_RD  = 3'd0,
        CFG_L1_WR  = 3'd1,
        CFG_L2_RD  = 3'd2,
        CFG_L2_WR  = 3'd3,
        CFG_MEM_RD = 3'd4,
        CFG_MEM_WR = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        logic [COST_W-1:0] l1_rd;
        logic [COST_W-1:0] l1_wr;
        logic [COST_W-1:0] l2_rd;
        logic [COST_W-1:0] l2_wr;
        logic [COST_W-1:0] mem_rd;
        logic [COST_W-1:0] mem_wr;
    } cost_t;

    // address width of a store, never below one bit
    function automatic int clog2m(input int v);
        return (v > 1) ? $clog2(v) : 1;
    endfunction

endpackage

`default_nettype wire

[rtl/two_level_writeback_cache.sv]
// Two-level direct-mapped write-back, write-allocate cache with cost accounting.
// Depends on twlc_pkg, twlc_cfg and twlc_ram.
//
// One item at a time. After reset a clearing pass zeroes the backing memory,
// during which no item is taken (cost writes are). An L1 read hit passes
// through S_L1_CHK, S_L1_OP, S_L1_RD and S_FIN after acceptance, a write hit skips
// S_L1_RD. Each L2 access adds the tag lookup states S_L2_TAG and S_L2_CHK plus a
// pass of the shared word-copy sequencer for every block moved (victim write-back,
// fill, transfer), so a miss costs between 1 and 6 block moves more. All line
// counts, block count and WORDS_PER_BLOCK must be powers of two. The result register
// lets the next item enter while a result is still waiting.
`default_nettype none

module two_level_writeback_cache #(
    parameter int WORDS_PER_BLOCK = 16,
    parameter int L1_LINES        = 64,
    parameter int L2_LINES        = 256,
    parameter int MEM_BLOCKS      = 1024
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic [twlc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [twlc_pkg::COST_W-1:0]      cfg_wdata,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic                             s_req_type,
    input  logic [twlc_pkg::ADDR_W-1:0]      s_byte_address,
    input  logic [twlc_pkg::WORD_W-1:0]      s_write_word,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [twlc_pkg::WORD_W-1:0]      m_read_word,
    output logic                             m_l1_hit,
    output logic                             m_l2_hit,
    output logic [twlc_pkg::TIME_W-1:0]      m_elapsed_time
);
    import twlc_pkg::*;

    localparam int WPB       = WORDS_PER_BLOCK;
    localparam int OFF_W     = clog2m(WPB);
    localparam int CNT_W     = $clog2(WPB + 1);
    localparam int BLK_W     = clog2m(MEM_BLOCKS);
    localparam int L1I_W     = clog2m(L1_LINES);
    localparam int L1T_W     = clog2m((MEM_BLOCKS + L1_LINES - 1) / L1_LINES);
    localparam int L2I_W     = clog2m(L2_LINES);
    localparam int L2T_W     = clog2m((MEM_BLOCKS + L2_LINES - 1) / L2_LINES);
    localparam int L1D_DEPTH = L1_LINES * WPB;
    localparam int L2D_DEPTH = L2_LINES * WPB;
    localparam int MEM_DEPTH = MEM_BLOCKS * WPB;
    localparam int L1D_AW    = clog2m(L1D_DEPTH);
    localparam int L2D_AW    = clog2m(L2D_DEPTH);
    localparam int MEM_AW    = clog2m(MEM_DEPTH);
    localparam int WADDR_W   = ADDR_W - 2;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_L1_CHK, S_L2_TAG, S_L2_CHK, S_COPY, S_L1_OP, S_L1_RD, S_FIN
    } state_t;

    typedef enum logic [1:0] {
        CP_L2_MEM, CP_MEM_L2, CP_L1_L2, CP_L2_L1
    } copy_kind_t;

    cost_t cost;

    state_t              state_reg;
    copy_kind_t          kind_reg;
    logic                req_wr_reg;
    logic [BLK_W-1:0]    blk_reg;
    logic [OFF_W-1:0]    off_reg;
    logic [WORD_W-1:0]   wdata_reg;
    logic                h1_reg;
    logic                h2_reg;
    logic [WORD_W-1:0]   rd_reg;
    logic [TIME_W-1:0]   time_reg;
    logic [BLK_W-1:0]    l2blk_reg;
    logic                l2wr_reg;
    logic [BLK_W-1:0]    mblk_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [MEM_AW-1:0]   clr_reg;
    logic [L1_LINES-1:0] l1_valid_reg;
    logic [L1_LINES-1:0] l1_dirty_reg;
    logic [L2_LINES-1:0] l2_valid_reg;
    logic [L2_LINES-1:0] l2_dirty_reg;
    logic                m_valid_reg;
    logic [WORD_W-1:0]   m_read_word_reg;
    logic                m_l1_hit_reg;
    logic                m_l2_hit_reg;
    logic [TIME_W-1:0]   m_time_reg;

    // address split
    logic [WADDR_W-1:0] in_waddr;
    logic [BLK_W-1:0]   in_blk;
    logic [OFF_W-1:0]   in_off;
    logic [L1I_W-1:0]   in_l1idx;
    logic [L1I_W-1:0]   l1idx;
    logic [L1T_W-1:0]   l1tag;
    logic [L2I_W-1:0]   l2idx;
    logic [L2T_W-1:0]   l2tag;
    logic [L1T_W-1:0]   l1_tag_q;
    logic [L2T_W-1:0]   l2_tag_q;
    logic               l1_hit_c;
    logic               l2_hit_c;
    logic [BLK_W-1:0]   l1_vblk;
    logic [BLK_W-1:0]   l2_vblk;

    assign in_waddr = s_byte_address[ADDR_W-1:2];
    assign in_blk   = BLK_W'((in_waddr / WPB) % MEM_BLOCKS);
    assign in_off   = OFF_W'(in_waddr % WPB);
    assign in_l1idx = L1I_W'(in_blk % L1_LINES);
    assign l1idx    = L1I_W'(blk_reg % L1_LINES);
    assign l1tag    = L1T_W'(blk_reg / L1_LINES);
    assign l2idx    = L2I_W'(l2blk_reg % L2_LINES);
    assign l2tag    = L2T_W'(l2blk_reg / L2_LINES);
    assign l1_hit_c = l1_valid_reg[l1idx] && (l1_tag_q == l1tag);
    assign l2_hit_c = l2_valid_reg[l2idx] && (l2_tag_q == l2tag);
    assign l1_vblk  = BLK_W'((32'(l1_tag_q) * L1_LINES + 32'(l1idx)) % MEM_BLOCKS);
    assign l2_vblk  = BLK_W'((32'(l2_tag_q) * L2_LINES + 32'(l2idx)) % MEM_BLOCKS);

    // word-copy sequencer addressing: read word cnt, write word cnt-1
    logic [OFF_W-1:0]  rd_off;
    logic [OFF_W-1:0]  wr_off;
    logic              copy_done;
    logic              copy_wen;
    logic [L1D_AW-1:0] l1_line_rd, l1_line_wr, l1_word_a;
    logic [L2D_AW-1:0] l2_line_rd, l2_line_wr;
    logic [MEM_AW-1:0] mem_line_rd, mem_line_wr;

    assign rd_off      = OFF_W'(cnt_reg);
    assign wr_off      = OFF_W'(cnt_reg - CNT_W'(1));
    assign copy_done   = (cnt_reg == CNT_W'(WPB));
    assign copy_wen    = (state_reg == S_COPY) && (cnt_reg != '0);
    assign l1_line_rd  = L1D_AW'(32'(l1idx) * WPB + 32'(rd_off));
    assign l1_line_wr  = L1D_AW'(32'(l1idx) * WPB + 32'(wr_off));
    assign l1_word_a   = L1D_AW'(32'(l1idx) * WPB + 32'(off_reg));
    assign l2_line_rd  = L2D_AW'(32'(l2idx) * WPB + 32'(rd_off));
    assign l2_line_wr  = L2D_AW'(32'(l2idx) * WPB + 32'(wr_off));
    assign mem_line_rd = MEM_AW'(32'(mblk_reg) * WPB + 32'(rd_off));
    assign mem_line_wr = MEM_AW'(32'(mblk_reg) * WPB + 32'(wr_off));

    // RAM ports
    logic                l1t_we;
    logic                l2t_we;
    logic                l1d_we, l2d_we, mem_we;
    logic [L1D_AW-1:0]   l1d_raddr, l1d_waddr;
    logic [WORD_W-1:0]   l1d_wdata, l1d_rdata, l2d_rdata, mem_rdata, mem_wdata, src_word;
    logic [MEM_AW-1:0]   mem_waddr;
    logic [COST_W-1:0]   add_cost;

    always_comb begin
        case (kind_reg)
            CP_MEM_L2: src_word = mem_rdata;
            CP_L1_L2:  src_word = l1d_rdata;
            default:   src_word = l2d_rdata;
        endcase
    end

    assign l1t_we    = (state_reg == S_COPY) && (kind_reg == CP_L2_L1) && copy_done;
    assign l2t_we    = (state_reg == S_L2_CHK) && !l2_hit_c;
    assign l1d_raddr = (state_reg == S_COPY) ? l1_line_rd : l1_word_a;
    assign l1d_we    = (copy_wen && (kind_reg == CP_L2_L1))
                    || ((state_reg == S_L1_OP) && req_wr_reg);
    assign l1d_waddr = (state_reg == S_COPY) ? l1_line_wr : l1_word_a;
    assign l1d_wdata = (state_reg == S_COPY) ? src_word : wdata_reg;
    assign l2d_we    = copy_wen && ((kind_reg == CP_MEM_L2) || (kind_reg == CP_L1_L2));
    assign mem_we    = (state_reg == S_CLEAR) || (copy_wen && (kind_reg == CP_L2_MEM));
    assign mem_waddr = (state_reg == S_CLEAR) ? clr_reg : mem_line_wr;
    assign mem_wdata = (state_reg == S_CLEAR) ? '0 : src_word;

    // single accumulator input: at most one cost lands per cycle
    always_comb begin
        add_cost = '0;
        if (state_reg == S_L1_OP) begin
            add_cost = req_wr_reg ? cost.l1_wr : cost.l1_rd;
        end else if ((state_reg == S_COPY) && copy_done) begin
            case (kind_reg)
                CP_L2_MEM: add_cost = cost.mem_wr;
                CP_MEM_L2: add_cost = cost.mem_rd;
                CP_L1_L2:  add_cost = cost.l2_wr;
                default:   add_cost = cost.l2_rd;
            endcase
        end
    end

    twlc_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cost      (cost)
    );

    twlc_ram #(.WIDTH(L1T_W), .DEPTH(L1_LINES)) u_l1_tag (
        .aclk (aclk), .we (l1t_we), .waddr (l1idx), .wdata (l1tag),
        .raddr (in_l1idx), .rdata (l1_tag_q)
    );

    twlc_ram #(.WIDTH(L2T_W), .DEPTH(L2_LINES)) u_l2_tag (
        .aclk (aclk), .we (l2t_we), .waddr (l2idx), .wdata (l2tag),
        .raddr (l2idx), .rdata (l2_tag_q)
    );

    twlc_ram #(.WIDTH(WORD_W), .DEPTH(L1D_DEPTH)) u_l1_data (
        .aclk (aclk), .we (l1d_we), .waddr (l1d_waddr), .wdata (l1d_wdata),
        .raddr (l1d_raddr), .rdata (l1d_rdata)
    );

    twlc_ram #(.WIDTH(WORD_W), .DEPTH(L2D_DEPTH)) u_l2_data (
        .aclk (aclk), .we (l2d_we), .waddr (l2_line_wr), .wdata (src_word),
        .raddr (l2_line_rd), .rdata (l2d_rdata)
    );

    twlc_ram #(.WIDTH(WORD_W), .DEPTH(MEM_DEPTH)) u_mem (
        .aclk (aclk), .we (mem_we), .waddr (mem_waddr), .wdata (mem_wdata),
        .raddr (mem_line_rd), .rdata (mem_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLEAR;
            kind_reg     <= CP_L2_MEM;
            clr_reg      <= '0;
            cnt_reg      <= '0;
            l2wr_reg     <= 1'b0;
            h1_reg       <= 1'b0;
            h2_reg       <= 1'b0;
            time_reg     <= '0;
            l1_valid_reg <= '0;
            l1_dirty_reg <= '0;
            l2_valid_reg <= '0;
            l2_dirty_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            time_reg <= time_reg + TIME_W'(add_cost);
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_CLEAR: begin
                    clr_reg <= clr_reg + MEM_AW'(1);
                    if (clr_reg == MEM_AW'(MEM_DEPTH - 1)) begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (s_valid) begin
                        req_wr_reg <= s_req_type;
                        blk_reg    <= in_blk;
                        off_reg    <= in_off;
                        wdata_reg  <= s_write_word;
                        h1_reg     <= 1'b0;
                        h2_reg     <= 1'b0;
                        state_reg  <= S_L1_CHK;
                    end
                end
                S_L1_CHK: begin
                    if (l1_hit_c) begin
                        h1_reg    <= 1'b1;
                        state_reg <= S_L1_OP;
                    end else begin
                        // dirty victim goes back to L2 before the fill
                        if (l1_valid_reg[l1idx] && l1_dirty_reg[l1idx]) begin
                            l2blk_reg <= l1_vblk;
                            l2wr_reg  <= 1'b1;
                        end else begin
                            l2blk_reg <= blk_reg;
                            l2wr_reg  <= 1'b0;
                        end
                        state_reg <= S_L2_TAG;
                    end
                end
                S_L2_TAG: begin
                    state_reg <= S_L2_CHK;
                end
                S_L2_CHK: begin
                    if (!l2wr_reg) begin
                        h2_reg <= l2_hit_c;
                    end
                    cnt_reg <= '0;
                    if (l2_hit_c) begin
                        kind_reg <= l2wr_reg ? CP_L1_L2 : CP_L2_L1;
                    end else begin
                        l2_valid_reg[l2idx] <= 1'b1;
                        l2_dirty_reg[l2idx] <= 1'b0;
                        if (l2_valid_reg[l2idx] && l2_dirty_reg[l2idx]) begin
                            kind_reg <= CP_L2_MEM;
                            mblk_reg <= l2_vblk;
                        end else begin
                            kind_reg <= CP_MEM_L2;
                            mblk_reg <= l2blk_reg;
                        end
                    end
                    state_reg <= S_COPY;
                end
                S_COPY: begin
                    if (!copy_done) begin
                        cnt_reg <= cnt_reg + CNT_W'(1);
                    end else begin
                        cnt_reg <= '0;
                        case (kind_reg)
                            CP_L2_MEM: begin
                                kind_reg <= CP_MEM_L2;
                                mblk_reg <= l2blk_reg;
                            end
                            CP_MEM_L2: begin
                                kind_reg <= l2wr_reg ? CP_L1_L2 : CP_L2_L1;
                            end
                            CP_L1_L2: begin
                                l2_dirty_reg[l2idx] <= 1'b1;
                                l2blk_reg <= blk_reg;
                                l2wr_reg  <= 1'b0;
                                state_reg <= S_L2_TAG;
                            end
                            default: begin
                                l1_valid_reg[l1idx] <= 1'b1;
                                l1_dirty_reg[l1idx] <= 1'b0;
                                state_reg <= S_L1_OP;
                            end
                        endcase
                    end
                end
                S_L1_OP: begin
                    if (req_wr_reg) begin
                        l1_dirty_reg[l1idx] <= 1'b1;
                        rd_reg    <= '0;
                        state_reg <= S_FIN;
                    end else begin
                        state_reg <= S_L1_RD;
                    end
                end
                S_L1_RD: begin
                    rd_reg    <= l1d_rdata;
                    state_reg <= S_FIN;
                end
                S_FIN: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg     <= 1'b1;
                        m_read_word_reg <= rd_reg;
                        m_l1_hit_reg    <= h1_reg;
                        m_l2_hit_reg    <= h2_reg;
                        m_time_reg      <= time_reg;
                        state_reg       <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_ready        = (state_reg == S_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_read_word    = m_read_word_reg;
    assign m_l1_hit       = m_l1_hit_reg;
    assign m_l2_hit       = m_l2_hit_reg;
    assign m_elapsed_time = m_time_reg;

    a_hit_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> !(m_l1_hit_reg && m_l2_hit_reg))
        else $error("L1 and L2 hit both flagged");

    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("second item taken while one is in progress");

    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(WORDS_PER_BLOCK))
        else $error("copy counter ran past the block");

endmodule

`default_nettype wire

[rtl/twlc_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Depends on twlc_pkg for the address width helper.
`default_nettype none

module twlc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW = twlc_pkg::clog2m(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);
    import twlc_pkg::*;

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[rtl/twlc_cfg.sv]
// Latency cost registers, written through a plain indexed write port.
// Depends on twlc_pkg for the register codes and the cost struct.
`default_nettype none

module twlc_cfg (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic [twlc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [twlc_pkg::COST_W-1:0]      cfg_wdata,
    output twlc_pkg::cost_t                  cost
);
    import twlc_pkg::*;

    cost_t cost_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cost_reg.l1_rd  <= COST_W'(1);
            cost_reg.l1_wr  <= COST_W'(1);
            cost_reg.l2_rd  <= COST_W'(10);
            cost_reg.l2_wr  <= COST_W'(10);
            cost_reg.mem_rd <= COST_W'(100);
            cost_reg.mem_wr <= COST_W'(100);
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_L1_RD:  cost_reg.l1_rd  <= cfg_wdata;
                CFG_L1_WR:  cost_reg.l1_wr  <= cfg_wdata;
                CFG_L2_RD:  cost_reg.l2_rd  <= cfg_wdata;
                CFG_L2_WR:  cost_reg.l2_wr  <= cfg_wdata;
                CFG_MEM_RD: cost_reg.mem_rd <= cfg_wdata;
                CFG_MEM_WR: cost_reg.mem_wr <= cfg_wdata;
                default: ; // unused indexes are dropped
            endcase
        end
    end

    assign cost = cost_reg;

endmodule

`default_nettype wire

[tb/tb_top.sv]
// Self-checking testbench for two_level_writeback_cache.
// Depends on twlc_pkg and the cache RTL; drives requests, predicts results, compares.
`timescale 1ns / 1ps

module tb_top;
    import twlc_pkg::*;

    localparam int WPB = 16;
    localparam int L1N = 64;
    localparam int L2N = 256;
    localparam int MEMB = 1024;
    localparam int LIMIT = 3000000;

    typedef struct packed {
        logic        wr;
        logic [15:0] addr;
        logic [31:0] wdata;
    } req_t;

    typedef struct packed {
        logic [31:0] rdata;
        logic        h1;
        logic        h2;
        logic [31:0] tcount;
    } resp_t;

    logic aclk = 0;
    logic aresetn = 0;
    logic cfg_we = 0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [COST_W-1:0] cfg_wdata = '0;
    logic s_valid = 0;
    logic s_ready;
    logic s_req_type = 0;
    logic [ADDR_W-1:0] s_byte_address = '0;
    logic [WORD_W-1:0] s_write_word = '0;
    logic m_valid;
    logic m_ready = 0;
    logic [WORD_W-1:0] m_read_word;
    logic m_l1_hit, m_l2_hit;
    logic [TIME_W-1:0] m_elapsed_time;

    two_level_writeback_cache u_top (.*);

    always #6 aclk = ~aclk;

    // predictor state
    cost_t costs;
    bit l1v[L1N], l1d[L1N];
    int unsigned l1t[L1N];
    logic [31:0] l1w[L1N*WPB];
    bit l2v[L2N], l2d[L2N];
    int unsigned l2t[L2N];
    logic [31:0] l2w[L2N*WPB];
    logic [31:0] mem_words[MEMB*WPB];
    logic [31:0] clock_units;

    req_t  pending_reqs[$];
    resp_t expected_resps[$];
    int errors = 0;
    int cycles = 0;
    bit quiet_phase = 0;
    bit hold_req = 0;

    // block-wide L2 access; l1base is the L1 line base
    function automatic bit l2_move(int unsigned blk, bit is_wr, int unsigned l1base);
        int unsigned idx, tg, vb;
        bit hit;
        idx = blk % L2N;
        tg = blk / L2N;
        hit = l2v[idx] && l2t[idx] == tg;
        if (!hit) begin
            if (l2v[idx] && l2d[idx]) begin
                vb = (l2t[idx] * L2N + idx) % MEMB;
                for (int i = 0; i < WPB; i++) mem_words[vb*WPB+i] = l2w[idx*WPB+i];
                clock_units += costs.mem_wr;
            end
            for (int i = 0; i < WPB; i++) l2w[idx*WPB+i] = mem_words[blk*WPB+i];
            clock_units += costs.mem_rd;
            l2v[idx] = 1; l2t[idx] = tg; l2d[idx] = 0;
        end
        if (is_wr) begin
            for (int i = 0; i < WPB; i++) l2w[idx*WPB+i] = l1w[l1base+i];
            l2d[idx] = 1;
            clock_units += costs.l2_wr;
        end else begin
            for (int i = 0; i < WPB; i++) l1w[l1base+i] = l2w[idx*WPB+i];
            clock_units += costs.l2_rd;
        end
        return hit;
    endfunction

    function automatic resp_t predict_access(req_t r);
        int unsigned wa, blk, off, idx, tg, vb;
        bit dummy;
        resp_t o;
        wa = r.addr >> 2;
        blk = (wa / WPB) % MEMB;
        off = wa % WPB;
        idx = blk % L1N;
        tg = blk / L1N;
        o = '0;
        o.h1 = l1v[idx] && l1t[idx] == tg;
        if (!o.h1) begin
            if (l1v[idx] && l1d[idx]) begin
                vb = (l1t[idx] * L1N + idx) % MEMB;
                dummy = l2_move(vb, 1'b1, idx*WPB);
            end
            o.h2 = l2_move(blk, 1'b0, idx*WPB);
            l1v[idx] = 1; l1t[idx] = tg; l1d[idx] = 0;
        end
        if (r.wr) begin
            l1w[idx*WPB+off] = r.wdata;
            l1d[idx] = 1;
            clock_units += costs.l1_wr;
        end else begin
            o.rdata = l1w[idx*WPB+off];
            clock_units += costs.l1_rd;
        end
        o.tcount = clock_units;
        return o;
    endfunction

    // driver
    int idle_left = 0;
    always @(posedge aclk) begin
        if (s_valid && s_ready) begin
            expected_resps.push_back(predict_access(
                {s_req_type, s_byte_address, s_write_word}));
        end
        if (!s_valid || s_ready) begin
            if (idle_left > 0) begin
                idle_left <= idle_left - 1;
                s_valid <= 0;
            end else if (pending_reqs.size() > 0
                    && (quiet_phase || $urandom_range(0, 3) != 0)) begin
                req_t r;
                r = pending_reqs.pop_front();
                s_valid <= 1;
                s_req_type <= r.wr;
                s_byte_address <= r.addr;
                s_write_word <= r.wdata;
            end else begin
                s_valid <= 0;
                if (!quiet_phase) idle_left <= $urandom_range(0, 2);
            end
        end
    end

    // receiver stall bursts and one long hold-off
    int stall_left = 0;
    int hold_left = 0;
    bit hold_done = 0;
    always @(posedge aclk) begin
        if (hold_req && !hold_done) begin
            hold_done <= 1;
            hold_left <= 3000;
            m_ready <= 0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready <= 0;
        end else if (quiet_phase) begin
            m_ready <= 1;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_ready <= 0;
        end else if ($urandom_range(0, 4) == 0) begin
            stall_left <= $urandom_range(0, 2);
            m_ready <= 0;
        end else begin
            m_ready <= 1;
        end
    end

    // monitor
    always @(posedge aclk) begin
        if (m_valid && m_ready) begin
            resp_t want;
            if (expected_resps.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result at cycle %0d", cycles);
            end else begin
                want = expected_resps.pop_front();
                if (m_read_word !== want.rdata || m_l1_hit !== want.h1
                        || m_l2_hit !== want.h2 || m_elapsed_time !== want.tcount) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: exp rd=%h h1=%b h2=%b t=%0d got rd=%h h1=%b h2=%b t=%0d",
                            want.rdata, want.h1, want.h2, want.tcount,
                            m_read_word, m_l1_hit, m_l2_hit, m_elapsed_time);
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    function automatic req_t rand_req();
        req_t r;
        r.wr = 1'($urandom_range(0, 1));
        r.wdata = $urandom;
        case ($urandom_range(0, 3))
            // few hot blocks: many hits
            0, 1: r.addr = {4'd0, 4'($urandom_range(0, 3)), 8'($urandom_range(0, 255))};
            // same L1 index, different tags: conflict and writeback
            2: r.addr = {4'($urandom_range(0, 15)), 6'd5, 6'($urandom_range(0, 63))};
            default: r.addr = 16'($urandom);
        endcase
        return r;
    endfunction

    task automatic write_cost(cfg_idx_t idx, logic [COST_W-1:0] v);
        @(posedge aclk);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_wdata <= v;
        case (idx)
            CFG_L1_RD:  costs.l1_rd = v;
            CFG_L1_WR:  costs.l1_wr = v;
            CFG_L2_RD:  costs.l2_rd = v;
            CFG_L2_WR:  costs.l2_wr = v;
            CFG_MEM_RD: costs.mem_rd = v;
            default:    costs.mem_wr = v;
        endcase
        @(posedge aclk);
        cfg_we <= 0;
    endtask

    task automatic drain();
        wait (pending_reqs.size() == 0 && !s_valid && expected_resps.size() == 0);
        repeat (200) @(posedge aclk);
    endtask

    task automatic set_all(logic [COST_W-1:0] a, b, c, d, e, f);
        write_cost(CFG_L1_RD, a);
        write_cost(CFG_L1_WR, b);
        write_cost(CFG_L2_RD, c);
        write_cost(CFG_L2_WR, d);
        write_cost(CFG_MEM_RD, e);
        write_cost(CFG_MEM_WR, f);
    endtask

    initial begin
        costs = '{l1_rd: 1, l1_wr: 1, l2_rd: 10, l2_wr: 10, mem_rd: 100, mem_wr: 100};
        clock_units = 0;
        foreach (l1v[i]) begin l1v[i] = 0; l1d[i] = 0; l1t[i] = 0; end
        foreach (l2v[i]) begin l2v[i] = 0; l2d[i] = 0; l2t[i] = 0; end
        foreach (mem_words[i]) mem_words[i] = '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1;

        // directed: extremes, both ops, L1 conflict with dirty victim, L2 conflict, wrap
        pending_reqs.push_back('{1'b0, 16'h0000, 32'h0});
        pending_reqs.push_back('{1'b1, 16'h0003, 32'hFFFF_FFFF});
        pending_reqs.push_back('{1'b0, 16'h0000, 32'hFFFF_FFFF});
        pending_reqs.push_back('{1'b1, 16'hFFFF, 32'hA5A5_5A5A});
        pending_reqs.push_back('{1'b0, 16'hFFFC, 32'h0});
        pending_reqs.push_back('{1'b1, 16'h1000, 32'h1234_5678}); // same L1 idx as 0
        pending_reqs.push_back('{1'b0, 16'h0004, 32'h0});
        pending_reqs.push_back('{1'b1, 16'h4000, 32'h5555_AAAA}); // same L2 idx as 0
        pending_reqs.push_back('{1'b1, 16'h8000, 32'hAAAA_5555});
        pending_reqs.push_back('{1'b0, 16'h0000, 32'h0});
        pending_reqs.push_back('{1'b0, 16'h4000, 32'h0});
        pending_reqs.push_back('{1'b0, 16'hC03C, 32'h0});
        pending_reqs.push_back('{1'b0, 16'h1000, 32'h0});
        drain();

        set_all(10'h3FF, 10'h3FF, 10'h3FF, 10'h3FF, 10'h3FF, 10'h3FF);
        repeat (100) pending_reqs.push_back(rand_req());
        drain();

        set_all(10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0);
        repeat (60) pending_reqs.push_back(rand_req());
        drain();

        // long receiver hold-off while requests keep coming
        hold_req = 1;
        repeat (30) pending_reqs.push_back(rand_req());
        wait (hold_done && hold_left == 0);
        drain();

        set_all(COST_W'($urandom), COST_W'($urandom), COST_W'($urandom),
                COST_W'($urandom), COST_W'($urandom), COST_W'($urandom));
        repeat (140) pending_reqs.push_back(rand_req());
        drain();

        quiet_phase = 1;
        repeat (70) pending_reqs.push_back(rand_req());
        drain();

        if (errors == 0 && expected_resps.size() == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end
endmodule
